// ===== src/assert_macros.svh =====
// Assertion helpers included by the allocator unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Checks a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

// ===== src/ffba_pkg.sv =====
`timescale 1ns / 1ps
package ffba_pkg;
  localparam int MaxBlocks = 64;
  localparam int MaxRequest = 512;
  localparam int NumClasses = 6;
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = IdxW + 1;
  localparam int AddrW = 20;
  localparam int SizeW = 10;
  localparam int BrkW = 21;
  localparam logic [BrkW-1:0] AddrSpace = BrkW'(1048576);

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StBadSize = 2'd1;
  localparam logic [1:0] StNoMem = 2'd2;
  localparam logic [1:0] StNotAlloc = 2'd3;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE  = 4'b0001,
    CMD_REUSE = 4'b0010,
    CMD_FREE  = 4'b0100,
    CMD_NEW   = 4'b1000
  } cmd_kind_t;

  // Search wave that walks the cell chain one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             op;
    logic [SizeW-1:0] req;
    logic [AddrW-1:0] addr;
    logic             found;
    logic [IdxW-1:0]  best;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] baddr;
    logic             inv_found;
    logic [IdxW-1:0]  inv_idx;
  } wave_t;

  // Update broadcast to every cell when a request is decided.
  typedef struct packed {
    cmd_kind_t        kind;
    logic [IdxW-1:0]  idx;
    logic [IdxW-1:0]  best;
    logic [IdxW-1:0]  rank;
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] size;
  } cmd_t;
endpackage

// ===== src/ffba_cell.sv =====
`timescale 1ns / 1ps
module ffba_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [ffba_pkg::IdxW-1:0] cell_idx,
  input  ffba_pkg::wave_t         wave_in,
  output ffba_pkg::wave_t         wave_out,
  input  ffba_pkg::cmd_t          cmd
);
  logic                          valid, is_free;
  logic [ffba_pkg::AddrW-1:0]    addr;
  logic [ffba_pkg::SizeW-1:0]    size;
  logic [ffba_pkg::IdxW-1:0]     rank;
  ffba_pkg::wave_t               w;
  logic                          hit;

  // The cell folds itself into the passing wave.
  always_comb begin
    w = wave_in;
    if (wave_in.op == ffba_pkg::OpAlloc) begin
      hit = valid && is_free && size >= wave_in.req &&
            (!wave_in.found || rank < wave_in.best);
    end else begin
      hit = valid && !is_free && addr == wave_in.addr && !wave_in.found;
    end
    if (hit) begin
      w.found = 1'b1;
      w.best = rank;
      w.idx = cell_idx;
      w.baddr = addr;
    end
    if (!valid && !wave_in.inv_found) begin
      w.inv_found = 1'b1;
      w.inv_idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.valid <= 1'b0;
    end else begin
      wave_out.valid <= wave_in.valid;
    end
    wave_out.op <= w.op;
    wave_out.req <= w.req;
    wave_out.addr <= w.addr;
    wave_out.found <= w.found;
    wave_out.best <= w.best;
    wave_out.idx <= w.idx;
    wave_out.baddr <= w.baddr;
    wave_out.inv_found <= w.inv_found;
    wave_out.inv_idx <= w.inv_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      is_free <= 1'b0;
    end else begin
      unique case (cmd.kind)
        ffba_pkg::CMD_REUSE: begin
          if (cmd.idx == cell_idx) begin
            is_free <= 1'b0;
            rank <= '0;
          end else if (valid && is_free && rank > cmd.best) begin
            rank <= rank - 1'b1;
          end
        end
        ffba_pkg::CMD_FREE: begin
          if (cmd.idx == cell_idx) begin
            is_free <= 1'b1;
            rank <= cmd.rank;
          end
        end
        ffba_pkg::CMD_NEW: begin
          if (cmd.idx == cell_idx) begin
            valid <= 1'b1;
            is_free <= 1'b0;
            addr <= cmd.addr;
            size <= cmd.size;
            rank <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== src/first_fit_block_allocator_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tdata: request_size, free_address; tuser: op
// m_*       out        m_tvalid/m_tready  tdata: block_address, status
// cfg_*     in         cfg_we             cfg_index, cfg_data
//
// The search wave crosses the row of 64 cells one cell per cycle, a register
// holds the finished wave, and the decision updates all cells.
// Only one item is in the cell row at a time; a new item is taken once the
// previous one has been decided, even while its result waits at the output.
// Reset is synchronous and clears all blocks, counters and the break pointer.
// A stalled output holds the decision until the result register is free.
`include "assert_macros.svh"
module first_fit_block_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [9:0] request_size, [29:10] free_address, rest zero
  input  logic [0:0]  s_tuser,  // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // [19:0] block_address, [21:20] status, rest zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_data
);
  localparam int N = ffba_pkg::MaxBlocks;

  // Configuration registers.
  logic [ffba_pkg::SizeW-1:0] class_size [ffba_pkg::NumClasses];
  logic [ffba_pkg::BrkW-1:0]  heap_limit;

  // Global allocator state.
  logic [ffba_pkg::CntW-1:0] free_count, block_count;
  logic [ffba_pkg::BrkW-1:0] break_pointer;
  logic                      busy;

  ffba_pkg::wave_t wave [N+1];
  ffba_pkg::wave_t done;
  ffba_pkg::cmd_t  cmd;
  logic            decide;
  logic [ffba_pkg::AddrW-1:0] res_addr;
  logic [1:0]                 res_status;
  logic [ffba_pkg::SizeW-1:0] csize;
  logic [ffba_pkg::BrkW-1:0]  limit;
  logic [ffba_pkg::BrkW:0]    brk_sum;

  assign s_tready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_size[0] <= 10'd16;
      class_size[1] <= 10'd32;
      class_size[2] <= 10'd64;
      class_size[3] <= 10'd128;
      class_size[4] <= 10'd256;
      class_size[5] <= 10'd512;
      heap_limit <= 21'd65536;
    end else if (cfg_we) begin
      if (cfg_index < 3'(ffba_pkg::NumClasses)) begin
        class_size[cfg_index] <= cfg_data[ffba_pkg::SizeW-1:0];
      end else if (cfg_index == 3'(ffba_pkg::NumClasses)) begin
        heap_limit <= cfg_data;
      end
    end
  end

  // The wave is launched into the first cell with nothing found yet.
  always_comb begin
    wave[0] = '0;
    wave[0].valid = s_tvalid && s_tready;
    wave[0].op = s_tuser[0];
    wave[0].req = s_tdata[9:0];
    wave[0].addr = s_tdata[29:10];
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    ffba_cell u_cell (
      .clk(clk), .rst(rst), .cell_idx(ffba_pkg::IdxW'(i)),
      .wave_in(wave[i]), .wave_out(wave[i+1]), .cmd(cmd)
    );
  end

  // Holds the finished wave until the result register can take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      done.valid <= 1'b0;
    end else if (wave[N].valid) begin
      done <= wave[N];
    end else if (decide) begin
      done.valid <= 1'b0;
    end
  end

  assign decide = done.valid && (!m_tvalid || m_tready);

  // Classes are scanned in register order; the first that holds the request wins.
  always_comb begin
    csize = '0;
    for (int k = ffba_pkg::NumClasses - 1; k >= 0; k--) begin
      if (class_size[k] >= done.req) csize = class_size[k];
    end
    limit = (heap_limit < ffba_pkg::AddrSpace) ? heap_limit : ffba_pkg::AddrSpace;
    brk_sum = {1'b0, break_pointer} + (ffba_pkg::BrkW+1)'(csize);
  end

  always_comb begin
    cmd = '0;
    cmd.kind = ffba_pkg::CMD_NONE;
    cmd.idx = done.idx;
    cmd.best = done.best;
    cmd.rank = free_count[ffba_pkg::IdxW-1:0];
    cmd.addr = break_pointer[ffba_pkg::AddrW-1:0];
    cmd.size = csize;
    res_addr = '0;
    res_status = ffba_pkg::StOk;
    if (done.op == ffba_pkg::OpFree) begin
      if (done.found) begin
        cmd.kind = ffba_pkg::CMD_FREE;
        res_addr = done.baddr;
      end else begin
        res_status = ffba_pkg::StNotAlloc;
      end
    end else if (done.req == '0 || done.req > ffba_pkg::SizeW'(ffba_pkg::MaxRequest)) begin
      res_status = ffba_pkg::StBadSize;
    end else if (done.found) begin
      cmd.kind = ffba_pkg::CMD_REUSE;
      res_addr = done.baddr;
    end else if (csize == '0) begin
      res_status = ffba_pkg::StBadSize;
    end else if (brk_sum > {1'b0, limit} || block_count >= ffba_pkg::CntW'(N)
                 || !done.inv_found) begin
      res_status = ffba_pkg::StNoMem;
    end else begin
      cmd.kind = ffba_pkg::CMD_NEW;
      cmd.idx = done.inv_idx;
      res_addr = break_pointer[ffba_pkg::AddrW-1:0];
    end
    if (!decide) cmd.kind = ffba_pkg::CMD_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      m_tvalid <= 1'b0;
      free_count <= '0;
      block_count <= '0;
      break_pointer <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        busy <= 1'b1;
      end else if (decide) begin
        busy <= 1'b0;
      end
      if (decide) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (cmd.kind)
        ffba_pkg::CMD_FREE:  free_count <= free_count + 1'b1;
        ffba_pkg::CMD_REUSE: free_count <= free_count - 1'b1;
        ffba_pkg::CMD_NEW: begin
          block_count <= block_count + 1'b1;
          break_pointer <= brk_sum[ffba_pkg::BrkW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (decide) m_tdata <= {2'b00, res_status, res_addr};
  end

  `ASSERT_CLK(a_busy_blocks_input, clk, rst, busy |-> !s_tready)
  `ASSERT_CLK(a_count_bound, clk, rst, block_count <= ffba_pkg::CntW'(N))
  `ASSERT_CLK(a_free_le_blocks, clk, rst, free_count <= block_count)
  `ASSERT_CLK(a_decide_busy, clk, rst, decide |-> busy)
endmodule
